// ===== src/binomial_lattice_option_pricer_assert.svh =====
`ifndef BINOMIAL_LATTICE_OPTION_PRICER_ASSERT_SVH
`define BINOMIAL_LATTICE_OPTION_PRICER_ASSERT_SVH

// checked only out of reset
`define BLOP_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("blop assertion failed");

// checked through reset as well
`define BLOP_ASSERT_ALWAYS(name, clk, ante, cons) \
    name: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("blop assertion failed");

`endif

// ===== src/blop_pkg.sv =====
package blop_pkg;

    localparam int MAX_STEPS       = 256;
    localparam int EXERCISE_PERIOD = 10;
    localparam int STEP_W          = $clog2(MAX_STEPS + 1);
    localparam int LAT_DEPTH       = MAX_STEPS + 1;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
    localparam logic [31:0] MAX32   = 32'hFFFF_FFFF;

    localparam logic [2:0] OP_EUR_CALL = 3'd0;
    localparam logic [2:0] OP_EUR_PUT  = 3'd1;
    localparam logic [2:0] OP_AME_CALL = 3'd2;
    localparam logic [2:0] OP_AME_PUT  = 3'd3;
    localparam logic [2:0] OP_BER_PUT  = 3'd4;
    localparam logic [2:0] OP_UPO_CALL = 3'd5;
    localparam logic [2:0] OP_DKO_CALL = 3'd6;

    localparam logic [2:0] CFG_STEPS    = 3'd0;
    localparam logic [2:0] CFG_UP       = 3'd1;
    localparam logic [2:0] CFG_DOWN     = 3'd2;
    localparam logic [2:0] CFG_W_UP     = 3'd3;
    localparam logic [2:0] CFG_W_DOWN   = 3'd4;
    localparam logic [2:0] CFG_STRIKE   = 3'd5;
    localparam logic [2:0] CFG_BAR_HIGH = 3'd6;
    localparam logic [2:0] CFG_BAR_LOW  = 3'd7;

    typedef struct packed {
        logic [31:0] spot;
        logic [2:0]  operation;
    } t_in;

    typedef struct packed {
        logic [31:0] price;
        logic        saturated;
    } t_out;

    typedef struct packed {
        logic [8:0]  steps;
        logic [31:0] up_factor;
        logic [31:0] down_factor;
        logic [31:0] weight_up;
        logic [31:0] weight_down;
        logic [31:0] strike;
        logic [31:0] barrier_high;
        logic [31:0] barrier_low;
    } t_cfg;

    typedef struct packed {
        logic [31:0] spot;
        logic        op_ok;
        logic        is_call;
        logic        up_out;
        logic        dbl_out;
        logic        american;
        logic        bermudan;
    } t_job;

    // {clip, value} of a Q2.30 product shifted down by 30
    function automatic logic [32:0] q30_clip(input logic [63:0] p);
        logic clip;
        clip = |p[63:62];
        return {clip, clip ? MAX32 : p[61:30]};
    endfunction

    function automatic logic [31:0] payoff(input logic [31:0] s, input logic [31:0] k,
                                           input logic is_call);
        logic [31:0] r;
        if (is_call) r = (s > k) ? s - k : 32'd0;
        else         r = (k > s) ? k - s : 32'd0;
        return r;
    endfunction

    function automatic logic is_dead(input logic [31:0] s, input t_job j,
                                     input logic [31:0] hi, input logic [31:0] lo);
        return ((j.up_out || j.dbl_out) && s >= hi) || (j.dbl_out && s <= lo);
    endfunction

endpackage

// ===== src/binomial_lattice_option_pricer.sv =====
// channel   | direction | handshake           | payload
// item      | in        | push / full         | i_item (spot, operation)
// result    | out       | empty / pop         | o_result (price, saturated)
// config    | in        | i_cfg_we, i_cfg_idx | i_cfg_data
// one item at a time through a single shared 32x32 multiplier
// per item: exercise-period residue, up/down power tables, leaf payoffs, backward induction;
// a node takes two more multiplies when an exercise or barrier test needs the node price
// unused operation codes go straight to the done state with a zero result
// synchronous active-low reset; two items queue while the engine works, one result waits
module binomial_lattice_option_pricer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  blop_pkg::t_in  i_item,
    output logic           empty,
    input  logic           pop,
    output blop_pkg::t_out o_result,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_idx,
    input  logic [31:0]    i_cfg_data
);
    import blop_pkg::*;

    t_cfg r_cfg;
    t_job job;
    logic job_valid, job_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.steps        <= 9'd1;
            r_cfg.up_factor    <= ONE_Q30;
            r_cfg.down_factor  <= ONE_Q30;
            r_cfg.weight_up    <= ONE_Q30 >> 1;
            r_cfg.weight_down  <= ONE_Q30 >> 1;
            r_cfg.strike       <= 32'd0;
            r_cfg.barrier_high <= MAX32;
            r_cfg.barrier_low  <= 32'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_STEPS:    r_cfg.steps        <= i_cfg_data[8:0];
                CFG_UP:       r_cfg.up_factor    <= i_cfg_data;
                CFG_DOWN:     r_cfg.down_factor  <= i_cfg_data;
                CFG_W_UP:     r_cfg.weight_up    <= i_cfg_data;
                CFG_W_DOWN:   r_cfg.weight_down  <= i_cfg_data;
                CFG_STRIKE:   r_cfg.strike       <= i_cfg_data;
                CFG_BAR_HIGH: r_cfg.barrier_high <= i_cfg_data;
                CFG_BAR_LOW:  r_cfg.barrier_low  <= i_cfg_data;
                default:      r_cfg.steps        <= r_cfg.steps;
            endcase
        end
    end

    blop_front u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full), .i_item,
        .o_job_valid(job_valid), .i_job_take(job_take), .o_job(job)
    );

    blop_engine u_engine (
        .i_clk, .i_rst_n, .i_cfg(r_cfg), .i_job_valid(job_valid), .o_job_take(job_take),
        .i_job(job), .o_empty(empty), .i_pop(pop), .o_result
    );
endmodule

// ===== src/blop_ram.sv =====
module blop_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 257
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/blop_front.sv =====
module blop_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_full,
    input  blop_pkg::t_in  i_item,
    output logic           o_job_valid,
    input  logic           i_job_take,
    output blop_pkg::t_job o_job
);
    import blop_pkg::*;

    t_job              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_cnt;
    t_job              n_job;
    logic              w_in, w_out;

    always_comb begin
        n_job.spot     = i_item.spot;
        n_job.op_ok    = i_item.operation <= OP_DKO_CALL;
        n_job.is_call  = i_item.operation == OP_EUR_CALL || i_item.operation == OP_AME_CALL ||
                         i_item.operation == OP_UPO_CALL || i_item.operation == OP_DKO_CALL;
        n_job.up_out   = i_item.operation == OP_UPO_CALL;
        n_job.dbl_out  = i_item.operation == OP_DKO_CALL;
        n_job.american = i_item.operation == OP_AME_CALL || i_item.operation == OP_AME_PUT;
        n_job.bermudan = i_item.operation == OP_BER_PUT;
    end

    assign o_full      = r_cnt == QCNT_W'(QUEUE_DEPTH);
    assign o_job_valid = r_cnt != '0;
    assign o_job       = r_q[r_rp];
    assign w_in        = i_push && !o_full;
    assign w_out       = i_job_take && o_job_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_in)  r_wp <= r_wp + 1'b1;
            if (w_out) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + QCNT_W'(w_in) - QCNT_W'(w_out);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in) begin
            r_q[r_wp] <= n_job;
        end
    end
endmodule

// ===== src/blop_engine.sv =====
module blop_engine (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  blop_pkg::t_cfg i_cfg,
    input  logic           i_job_valid,
    output logic           o_job_take,
    input  blop_pkg::t_job i_job,
    output logic           o_empty,
    input  logic           i_pop,
    output blop_pkg::t_out o_result
);
    import blop_pkg::*;

    localparam logic [4:0] S_IDLE = 5'd0,  S_MRED = 5'd1,  S_PINIT = 5'd2, S_PMU = 5'd3,
                           S_PMD  = 5'd4,  S_PWD  = 5'd5,  S_LRD   = 5'd6, S_LM1 = 5'd7,
                           S_LM2  = 5'd8,  S_LW   = 5'd9,  S_BLVL  = 5'd10, S_BLO = 5'd11,
                           S_BRD  = 5'd12, S_BM1  = 5'd13, S_BM2   = 5'd14, S_BSUM = 5'd15,
                           S_BP1  = 5'd16, S_BP2  = 5'd17, S_DONE  = 5'd18;

    logic [4:0]        r_state, n_state;
    logic              r_ovalid;
    t_out              r_out;
    t_job              r_job, n_job;
    logic [STEP_W-1:0] r_i, n_i, r_n, n_n, r_ns, n_ns, r_res, n_res;
    logic [31:0]       r_pu, n_pu, r_pd, n_pd, r_lo, n_lo, r_hi, n_hi, r_v, n_v;
    logic [63:0]       r_prod, r_acc, n_acc;
    logic              r_clip, n_clip;
    logic [31:0]       w_ma, w_mb;
    logic [32:0]       w_q;
    logic [64:0]       w_sum;
    logic [31:0]       w_sumv, w_leaf, w_fin, w_ex;
    logic              w_sumc, w_exer, w_need, w_adv;
    logic              up_we, dn_we, nd_we;
    logic [STEP_W-1:0] up_wa, dn_wa, nd_ra;
    logic [31:0]       up_wd, dn_wd, nd_wd, up_rd, dn_rd, nd_rd;

    blop_ram #(.WIDTH(32), .DEPTH(LAT_DEPTH)) u_up (
        .i_clk, .i_we(up_we), .i_waddr(up_wa), .i_wdata(up_wd), .i_raddr(r_i), .o_rdata(up_rd)
    );
    blop_ram #(.WIDTH(32), .DEPTH(LAT_DEPTH)) u_dn (
        .i_clk, .i_we(dn_we), .i_waddr(dn_wa), .i_wdata(dn_wd), .i_raddr(r_n - r_i),
        .o_rdata(dn_rd)
    );
    blop_ram #(.WIDTH(32), .DEPTH(LAT_DEPTH)) u_nd (
        .i_clk, .i_we(nd_we), .i_waddr(r_i), .i_wdata(nd_wd), .i_raddr(nd_ra), .o_rdata(nd_rd)
    );

    assign w_q    = q30_clip(r_prod);
    assign w_sum  = {1'b0, r_acc} + {1'b0, r_prod};
    assign w_sumc = |w_sum[64:62];
    assign w_sumv = w_sumc ? MAX32 : w_sum[61:30];
    assign w_exer = r_job.american || (r_job.bermudan && r_res == '0);
    assign w_need = w_exer || r_job.up_out || r_job.dbl_out;
    assign w_leaf = is_dead(w_q[31:0], r_job, i_cfg.barrier_high, i_cfg.barrier_low) ?
                    32'd0 : payoff(w_q[31:0], i_cfg.strike, r_job.is_call);
    assign w_ex   = payoff(w_q[31:0], i_cfg.strike, r_job.is_call);
    assign nd_ra  = (r_state == S_BLVL) ? '0 : r_i + 1'b1;
    assign o_empty  = !r_ovalid;
    assign o_result = r_out;

    always_comb begin
        w_fin = r_v;
        if (w_exer && w_ex > r_v) w_fin = w_ex;
        if (is_dead(w_q[31:0], r_job, i_cfg.barrier_high, i_cfg.barrier_low)) w_fin = 32'd0;
    end

    always_comb begin
        n_state = r_state; n_job = r_job; n_i = r_i; n_n = r_n; n_ns = r_ns; n_res = r_res;
        n_pu = r_pu; n_pd = r_pd; n_lo = r_lo; n_hi = r_hi; n_v = r_v; n_acc = r_acc;
        n_clip = r_clip;
        w_ma = 32'd0; w_mb = 32'd0; w_adv = 1'b0; o_job_take = 1'b0;
        up_we = 1'b0; dn_we = 1'b0; nd_we = 1'b0;
        up_wa = r_i; dn_wa = r_i; up_wd = w_q[31:0]; dn_wd = w_q[31:0]; nd_wd = w_sumv;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid && !r_ovalid) begin
                    o_job_take = 1'b1;
                    n_job  = i_job;
                    n_clip = 1'b0;
                    n_v    = 32'd0;
                    n_ns   = (32'(i_cfg.steps) > 32'(MAX_STEPS)) ? STEP_W'(MAX_STEPS) :
                                                                  STEP_W'(i_cfg.steps);
                    n_res  = n_ns;
                    n_n    = n_ns;
                    n_state = i_job.op_ok ? S_MRED : S_DONE;
                end
            end
            S_MRED: begin
                if (32'(r_res) >= 32'(EXERCISE_PERIOD)) begin
                    n_res = r_res - STEP_W'(EXERCISE_PERIOD);
                end else begin
                    n_state = S_PINIT;
                end
            end
            S_PINIT: begin
                up_we = 1'b1; dn_we = 1'b1; up_wa = '0; dn_wa = '0;
                up_wd = ONE_Q30; dn_wd = ONE_Q30;
                n_pu = ONE_Q30; n_pd = ONE_Q30;
                if (r_ns == '0) begin
                    n_i = '0; n_state = S_LRD;
                end else begin
                    n_i = STEP_W'(1); n_state = S_PMU;
                end
            end
            S_PMU: begin
                w_ma = r_pu; w_mb = i_cfg.up_factor; n_state = S_PMD;
            end
            S_PMD: begin
                w_ma = r_pd; w_mb = i_cfg.down_factor;
                up_we = 1'b1; n_pu = w_q[31:0]; n_clip = r_clip | w_q[32];
                n_state = S_PWD;
            end
            S_PWD: begin
                dn_we = 1'b1; n_pd = w_q[31:0]; n_clip = r_clip | w_q[32];
                if (r_i == r_ns) begin
                    n_i = '0; n_state = S_LRD;
                end else begin
                    n_i = r_i + 1'b1; n_state = S_PMU;
                end
            end
            S_LRD: n_state = S_LM1;
            S_LM1: begin
                w_ma = r_job.spot; w_mb = up_rd; n_state = S_LM2;
            end
            S_LM2: begin
                w_ma = w_q[31:0]; w_mb = dn_rd; n_clip = r_clip | w_q[32]; n_state = S_LW;
            end
            S_LW: begin
                nd_we = 1'b1; nd_wd = w_leaf; n_v = w_leaf; n_clip = r_clip | w_q[32];
                if (r_i == r_n) begin
                    if (r_n == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_n = r_n - 1'b1;
                        n_res = (r_res == '0) ? STEP_W'(EXERCISE_PERIOD - 1) : r_res - 1'b1;
                        n_state = S_BLVL;
                    end
                end else begin
                    n_i = r_i + 1'b1; n_state = S_LRD;
                end
            end
            S_BLVL: begin
                n_i = '0; n_state = S_BLO;
            end
            S_BLO: begin
                n_lo = nd_rd; n_state = S_BM1;
            end
            S_BRD: n_state = S_BM1;
            S_BM1: begin
                w_ma = i_cfg.weight_up; w_mb = nd_rd; n_hi = nd_rd; n_state = S_BM2;
            end
            S_BM2: begin
                w_ma = i_cfg.weight_down; w_mb = r_lo; n_acc = r_prod; n_state = S_BSUM;
            end
            S_BSUM: begin
                n_v = w_sumv; n_clip = r_clip | w_sumc;
                if (w_need) begin
                    w_ma = r_job.spot; w_mb = up_rd; n_state = S_BP1;
                end else begin
                    nd_we = 1'b1; nd_wd = w_sumv; w_adv = 1'b1;
                end
            end
            S_BP1: begin
                w_ma = w_q[31:0]; w_mb = dn_rd; n_clip = r_clip | w_q[32]; n_state = S_BP2;
            end
            S_BP2: begin
                nd_we = 1'b1; nd_wd = w_fin; n_v = w_fin; n_clip = r_clip | w_q[32];
                w_adv = 1'b1;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        if (w_adv) begin
            n_lo = r_hi;
            if (r_i == r_n) begin
                if (r_n == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_n = r_n - 1'b1;
                    n_res = (r_res == '0) ? STEP_W'(EXERCISE_PERIOD - 1) : r_res - 1'b1;
                    n_state = S_BLVL;
                end
            end else begin
                n_i = r_i + 1'b1; n_state = S_BRD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE) r_ovalid <= 1'b1;
            else if (i_pop)        r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job  <= n_job;  r_i  <= n_i;  r_n  <= n_n;  r_ns <= n_ns; r_res <= n_res;
        r_pu   <= n_pu;   r_pd <= n_pd; r_lo <= n_lo; r_hi <= n_hi; r_v   <= n_v;
        r_acc  <= n_acc;  r_clip <= n_clip;
        r_prod <= 64'(w_ma) * 64'(w_mb);
        if (r_state == S_DONE) begin
            r_out.price     <= r_v;
            r_out.saturated <= r_clip;
        end
    end
endmodule

// ===== src/blop_checker.sv =====
`include "binomial_lattice_option_pricer_assert.svh"

module blop_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           full,
    input logic           empty,
    input logic           pop,
    input blop_pkg::t_out o_result
);
    `BLOP_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, empty)
    `BLOP_ASSERT_ALWAYS(a_rst_not_full, i_clk, !i_rst_n, !full)
    `BLOP_ASSERT_NEXT(a_pop_drains, i_clk, i_rst_n, pop && !empty, empty)
    `BLOP_ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_result))
endmodule

bind binomial_lattice_option_pricer blop_checker u_blop_checker (
    .i_clk, .i_rst_n, .full, .empty, .pop, .o_result
);

// ===== tb/tb_binomial_lattice_option_pricer.sv =====
module tb_binomial_lattice_option_pricer;
    timeunit 1ns;
    timeprecision 1ps;
    import blop_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    t_in         i_item;
    logic        empty;
    logic        pop;
    t_out        o_result;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    binomial_lattice_option_pricer dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_item(i_item),
        .empty(empty), .pop(pop), .o_result(o_result), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    localparam longint CYCLE_LIMIT = 64'd40_000_000;
    localparam logic [2:0] OP_NONE = 3'd7;

    t_in  pending_items[$];
    t_out expected_prices[$];
    int   error_count = 0;
    longint cycle_count = 0;
    bit   hold_off_req = 0;
    bit   hold_off_busy = 0;
    int   hold_off_left = 0;
    int   send_gap = 0;
    int   recv_gap = 0;

    logic [8:0]  m_steps;
    logic [31:0] m_up, m_down, m_wup, m_wdown, m_strike, m_bhi, m_blo;
    logic [31:0] lat_vals[0:MAX_STEPS];
    logic [31:0] up_pow[0:MAX_STEPS];
    logic [31:0] dn_pow[0:MAX_STEPS];

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [31:0] mul30(input logic [31:0] a, input logic [31:0] b,
                                          inout bit clip);
        logic [63:0] p;
        p = (64'(a) * 64'(b)) >> 30;
        if (p > 64'hFFFF_FFFF) begin
            clip = 1;
            return 32'hFFFF_FFFF;
        end
        return p[31:0];
    endfunction

    function automatic logic [31:0] pay(input logic [31:0] s, input bit call_kind);
        if (call_kind) return (s > m_strike) ? s - m_strike : 32'd0;
        return (m_strike > s) ? m_strike - s : 32'd0;
    endfunction

    function automatic bit knocked_out(input logic [31:0] s, input logic [2:0] op);
        if (op == OP_UPO_CALL) return s >= m_bhi;
        if (op == OP_DKO_CALL) return s >= m_bhi || s <= m_blo;
        return 0;
    endfunction

    function automatic t_out price_option(input t_in it);
        t_out r;
        bit clip, call_kind, barrier, exer;
        int ns;
        logic [31:0] s, t, v, e;
        logic [63:0] a, b, q, mask;
        clip = 0;
        r = '0;
        if (it.operation > OP_DKO_CALL) return r;
        ns = (m_steps > MAX_STEPS) ? MAX_STEPS : m_steps;
        call_kind = it.operation inside {OP_EUR_CALL, OP_AME_CALL, OP_UPO_CALL, OP_DKO_CALL};
        barrier = it.operation >= OP_UPO_CALL;
        mask = (64'd1 << 30) - 1;
        up_pow[0] = ONE_Q30;
        dn_pow[0] = ONE_Q30;
        for (int k = 1; k <= ns; k++) begin
            up_pow[k] = mul30(up_pow[k-1], m_up, clip);
            dn_pow[k] = mul30(dn_pow[k-1], m_down, clip);
        end
        for (int i = 0; i <= ns; i++) begin
            t = mul30(it.spot, up_pow[i], clip);
            s = mul30(t, dn_pow[ns-i], clip);
            lat_vals[i] = knocked_out(s, it.operation) ? 32'd0 : pay(s, call_kind);
        end
        for (int n = ns - 1; n >= 0; n--) begin
            exer = (it.operation == OP_AME_CALL || it.operation == OP_AME_PUT) ||
                   (it.operation == OP_BER_PUT && (n % EXERCISE_PERIOD) == 0);
            for (int i = 0; i <= n; i++) begin
                a = 64'(m_wup) * 64'(lat_vals[i+1]);
                b = 64'(m_wdown) * 64'(lat_vals[i]);
                q = (a >> 30) + (b >> 30) + (((a & mask) + (b & mask)) >> 30);
                if (q > 64'hFFFF_FFFF) begin
                    clip = 1;
                    v = 32'hFFFF_FFFF;
                end else begin
                    v = q[31:0];
                end
                if (exer || barrier) begin
                    t = mul30(it.spot, up_pow[i], clip);
                    s = mul30(t, dn_pow[n-i], clip);
                    if (exer) begin
                        e = pay(s, call_kind);
                        if (e > v) v = e;
                    end
                    if (knocked_out(s, it.operation)) v = 32'd0;
                end
                lat_vals[i] = v;
            end
        end
        r.price = lat_vals[0];
        r.saturated = clip;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_binomial_lattice_option_pricer NOT OK");
            $finish;
        end
    end

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (push && !full) begin
            expected_prices.push_back(price_option(i_item));
            void'(pending_items.pop_front());
            send_gap = rand_gap();
            if (send_gap == 0 && pending_items.size() > 0) begin
                i_item <= pending_items[0];
                push <= 1'b1;
            end else begin
                push <= 1'b0;
            end
        end else if (!push) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending_items.size() > 0) begin
                i_item <= pending_items[0];
                push <= 1'b1;
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_prices.size() == 0) begin
                    report_mismatch("unexpected transaction", o_result.price, 32'd0);
                end else begin
                    if (o_result.price !== expected_prices[0].price)
                        report_mismatch("price", o_result.price, expected_prices[0].price);
                    if (o_result.saturated !== expected_prices[0].saturated)
                        report_mismatch("saturated", 32'(o_result.saturated),
                                        32'(expected_prices[0].saturated));
                    void'(expected_prices.pop_front());
                end
                recv_gap = rand_gap();
            end
            if (hold_off_req && !hold_off_busy) begin
                hold_off_busy = 1;
                hold_off_left = 4000;
            end
            if (hold_off_busy) begin
                pop <= 1'b0;
                hold_off_left--;
                if (hold_off_left <= 0) begin
                    hold_off_busy = 0;
                    hold_off_req = 0;
                end
            end else if (recv_gap > 0) begin
                pop <= 1'b0;
                recv_gap--;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_STEPS:    m_steps = val[8:0];
            CFG_UP:       m_up = val;
            CFG_DOWN:     m_down = val;
            CFG_W_UP:     m_wup = val;
            CFG_W_DOWN:   m_wdown = val;
            CFG_STRIKE:   m_strike = val;
            CFG_BAR_HIGH: m_bhi = val;
            default:      m_blo = val;
        endcase
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || push || expected_prices.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic add_item(input logic [31:0] spot, input logic [2:0] op);
        t_in it;
        it.spot = spot;
        it.operation = op;
        pending_items.push_back(it);
    endtask

    function automatic logic [31:0] rand_spot();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return $urandom;
        if (r == 1) return {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0};
        return 32'h0010_0000 + $urandom_range(0, 32'h00C0_0000);
    endfunction

    task automatic realistic_cfg(input int n);
        cfg_write(CFG_STEPS, n);
        cfg_write(CFG_UP, 32'h4000_0000 + $urandom_range(0, 32'h0400_0000));
        cfg_write(CFG_DOWN, 32'h4000_0000 - $urandom_range(0, 32'h0400_0000));
        cfg_write(CFG_W_UP, 32'h1F00_0000 + $urandom_range(0, 32'h0200_0000));
        cfg_write(CFG_W_DOWN, 32'h1F00_0000 + $urandom_range(0, 32'h0200_0000));
        cfg_write(CFG_STRIKE, 32'h0040_0000 + $urandom_range(0, 32'h0080_0000));
        cfg_write(CFG_BAR_HIGH, 32'h0080_0000 + $urandom_range(0, 32'h0080_0000));
        cfg_write(CFG_BAR_LOW, 32'h0010_0000 + $urandom_range(0, 32'h0030_0000));
    endtask

    initial begin
        push = 1'b0;
        pop = 1'b0;
        i_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_STEPS;
        i_cfg_data = '0;
        m_steps = 9'd1;
        m_up = ONE_Q30;
        m_down = ONE_Q30;
        m_wup = ONE_Q30 / 2;
        m_wdown = ONE_Q30 / 2;
        m_strike = '0;
        m_bhi = MAX32;
        m_blo = '0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, every operation and spot extremes
        for (int op = 0; op < 8; op++) add_item(32'h0001_0000, op[2:0]);
        add_item(32'd0, OP_DKO_CALL);
        add_item(32'hFFFF_FFFF, OP_EUR_CALL);
        drain();

        // zero steps, steps beyond the max, extreme factors
        cfg_write(CFG_STEPS, 0);
        cfg_write(CFG_STRIKE, 32'h0002_0000);
        cfg_write(CFG_BAR_HIGH, 32'h0003_0000);
        cfg_write(CFG_BAR_LOW, 32'h0001_0000);
        for (int op = 0; op < 7; op++) add_item(32'h0001_8000, op[2:0]);
        add_item(32'h0004_0000, OP_UPO_CALL);
        drain();
        cfg_write(CFG_STEPS, 32'h0000_01FF);
        cfg_write(CFG_UP, 32'hFFFF_FFFF);
        cfg_write(CFG_DOWN, 32'd0);
        cfg_write(CFG_W_UP, 32'hFFFF_FFFF);
        cfg_write(CFG_W_DOWN, 32'hFFFF_FFFF);
        cfg_write(CFG_STRIKE, 32'd0);
        cfg_write(CFG_BAR_HIGH, 32'hFFFF_FFFF);
        cfg_write(CFG_BAR_LOW, 32'd0);
        add_item(32'hFFFF_FFFF, OP_EUR_CALL);
        add_item(32'h0001_0000, OP_DKO_CALL);
        drain();

        // bermudan period boundary and a stretch where the receiver holds off
        realistic_cfg(EXERCISE_PERIOD * 2 + 1);
        hold_off_req = 1;
        for (int k = 0; k < 6; k++) add_item(rand_spot(), 3'($urandom_range(0, 7)));
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            realistic_cfg(phase == 7 ? MAX_STEPS : $urandom_range(1, 24));
            for (int k = 0; k < (phase == 7 ? 2 : 12); k++) begin
                if ($urandom_range(0, 19) == 0)
                    add_item($urandom, OP_NONE);
                else
                    add_item(rand_spot(), 3'($urandom_range(0, 6)));
            end
            drain();
        end

        if (error_count == 0) begin
            $display("tb_binomial_lattice_option_pricer OK");
        end else begin
            $display("tb_binomial_lattice_option_pricer NOT OK");
        end
        $finish;
    end
endmodule
